### sv/tshts_pkg.sv
package tshts_pkg;

   localparam int TSHTS_MAX_TAIL = 16;

   localparam int COORD_W    = 16;
   localparam int PRESSURE_W = 16;

   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 8;

   localparam int HEAD_SKIP_W = 8;
   localparam int TAIL_SKIP_W = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_HEAD_SKIP = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_TAIL_SKIP = CSR_IDX_W'(1);

   localparam logic [HEAD_SKIP_W-1:0] HEAD_SKIP_RST = HEAD_SKIP_W'(1);
   localparam logic [TAIL_SKIP_W-1:0] TAIL_SKIP_RST = TAIL_SKIP_W'(1);

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [PRESSURE_W-1:0]     p;
   } point_type;

   typedef struct packed {
      logic      valid;
      point_type point;
   } result_type;

endpackage

### sv/tshts_core.sv
module tshts_core
   import tshts_pkg::*;
#(
   parameter int MAX_TAIL = TSHTS_MAX_TAIL
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  take,
   input  point_type             sample,
   output result_type            result
);

   localparam int CW = $clog2(MAX_TAIL + 1);
   localparam int IW = (MAX_TAIL > 1) ? $clog2(MAX_TAIL) : 1;
   localparam logic [CW-1:0] MAX_DEPTH = CW'(MAX_TAIL);

   logic [HEAD_SKIP_W-1:0] head_skip_ff;
   logic [TAIL_SKIP_W-1:0] tail_skip_ff;
   logic [HEAD_SKIP_W-1:0] head_count_ff, head_count_in;
   logic [CW-1:0]          tail_index_ff, tail_index_in;
   logic                   stroke_sent_ff, stroke_sent_in;
   point_type              ring_ff [MAX_TAIL];

   logic [CW-1:0] depth;
   logic [CW-1:0] slot;
   logic          ring_we;
   logic [IW-1:0] ring_addr;
   point_type     ring_wdata;
   point_type     stored;
   logic          released;

   always_comb begin
      if (int'(tail_skip_ff) > MAX_TAIL) begin
         depth = MAX_DEPTH;
      end else begin
         depth = CW'(tail_skip_ff);
      end
      slot     = (tail_index_ff >= depth) ? '0 : tail_index_ff;
      stored   = ring_ff[slot[IW-1:0]];
      released = (sample.p == '0);

      head_count_in  = head_count_ff;
      tail_index_in  = tail_index_ff;
      stroke_sent_in = stroke_sent_ff;
      ring_we        = 1'b0;
      ring_addr      = tail_index_ff[IW-1:0];
      ring_wdata     = sample;
      result.valid   = 1'b0;
      result.point   = sample;

      if (take) begin
         if (head_count_ff < head_skip_ff) begin
            head_count_in = head_count_ff + HEAD_SKIP_W'(1);
            if (released) begin
               head_count_in  = '0;
               tail_index_in  = '0;
               stroke_sent_in = 1'b0;
            end
         end else if (released && !stroke_sent_ff) begin
            head_count_in  = '0;
            tail_index_in  = '0;
            stroke_sent_in = 1'b0;
         end else if (depth == '0) begin
            result.valid   = 1'b1;
            stroke_sent_in = 1'b1;
            if (released) begin
               head_count_in  = '0;
               tail_index_in  = '0;
               stroke_sent_in = 1'b0;
            end
         end else if (!stroke_sent_ff && (tail_index_ff < depth)) begin
            ring_we       = 1'b1;
            tail_index_in = tail_index_ff + CW'(1);
         end else begin
            result.valid = 1'b1;
            result.point = stored;
            if (released) begin
               result.point.p = '0;
               ring_we        = 1'b1;
               ring_addr      = slot[IW-1:0];
               ring_wdata     = stored;
               ring_wdata.p   = '0;
               head_count_in  = '0;
               tail_index_in  = '0;
               stroke_sent_in = 1'b0;
            end else begin
               ring_we        = 1'b1;
               ring_addr      = slot[IW-1:0];
               tail_index_in  = slot + CW'(1);
               stroke_sent_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_skip_ff   <= HEAD_SKIP_RST;
         tail_skip_ff   <= TAIL_SKIP_RST;
         head_count_ff  <= '0;
         tail_index_ff  <= '0;
         stroke_sent_ff <= 1'b0;
      end else begin
         head_count_ff  <= head_count_in;
         tail_index_ff  <= tail_index_in;
         stroke_sent_ff <= stroke_sent_in;
         if (csr_we) begin
            case (csr_index)
               CSR_HEAD_SKIP: head_skip_ff <= csr_wdata[HEAD_SKIP_W-1:0];
               CSR_TAIL_SKIP: tail_skip_ff <= csr_wdata[TAIL_SKIP_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_ff[ring_addr] <= ring_wdata;
      end
   end

endmodule

### sv/touch_stroke_head_tail_skip_unit.sv
// A result is registered in the result register or, on a stall, the skid register.
// One request per cycle while req_stall is low; each yields zero or one result.
// A result register and a skid register part the two sides; req_stall rises only
// when both hold a result that the downstream side has not yet taken.
// Reset clears the stroke state, the output buffers and the configuration registers
// (both skip counts to one); the sample ring keeps its contents.
module touch_stroke_head_tail_skip_unit
   import tshts_pkg::*;
#(
   parameter int MAX_TAIL = TSHTS_MAX_TAIL
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_W-1:0]    req_pos_x,
   input  logic signed [COORD_W-1:0]    req_pos_y,
   input  logic [PRESSURE_W-1:0]        req_pressure,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COORD_W-1:0]    rsp_out_x,
   output logic signed [COORD_W-1:0]    rsp_out_y,
   output logic [PRESSURE_W-1:0]        rsp_out_pressure,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata
);

   logic       take;
   point_type  sample;
   result_type res;

   logic      out_v_ff, out_v_in;
   point_type out_ff, out_in;
   logic      skid_v_ff, skid_v_in;
   point_type skid_ff, skid_in;

   assign csr_ready = 1'b1;
   assign req_stall = skid_v_ff;
   assign take      = req_valid && !req_stall;

   assign sample.x = req_pos_x;
   assign sample.y = req_pos_y;
   assign sample.p = req_pressure;

   tshts_core #(
      .MAX_TAIL(MAX_TAIL)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .take      (take),
      .sample    (sample),
      .result    (res)
   );

   always_comb begin
      out_v_in  = out_v_ff;
      out_in    = out_ff;
      skid_v_in = skid_v_ff;
      skid_in   = skid_ff;
      if (!out_v_ff || !rsp_stall) begin
         if (skid_v_ff) begin
            out_v_in  = 1'b1;
            out_in    = skid_ff;
            skid_v_in = res.valid;
            skid_in   = res.point;
         end else begin
            out_v_in = res.valid;
            out_in   = res.point;
         end
      end else if (res.valid) begin
         skid_v_in = 1'b1;
         skid_in   = res.point;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid        = out_v_ff;
   assign rsp_out_x        = out_ff.x;
   assign rsp_out_y        = out_ff.y;
   assign rsp_out_pressure = out_ff.p;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid register holds a result while the output register is empty");

   a_skid_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(out_v_ff && rsp_stall))
      else $error("skid register filled although the output register was free");

   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall))
      else $error("result appeared without an accepted request transaction");

endmodule
